// ----- src/dcl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcl_pkg
// Shared types, code tables and helpers for the implode stream decoder.
// ----------------------------------------------------------------------------
package dcl_pkg;

    localparam int HistDepth   = 4096;
    localparam int HistAw      = $clog2(HistDepth);
    localparam int BytesPerRes = 16;
    localparam int CntW        = $clog2(BytesPerRes + 1);
    localparam int QDepth      = 2;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_DIST = 2'd1,
        ERR_WIN  = 2'd2
    } err_t;

    // item handed from the front (bit parser) to the back (byte writer)
    typedef enum logic [1:0] {
        OP_LIT  = 2'd0,
        OP_COPY = 2'd1,
        OP_DONE = 2'd2
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] lit;
        logic [9:0] len;
        logic [HistAw:0] back;
        logic       last;
        logic       fin_end;
        err_t       err;
    } cmd_t;

    typedef enum logic [2:0] {
        TK_FLAG = 3'd0,
        TK_LIT  = 3'd1,
        TK_LEN  = 3'd2,
        TK_EXT  = 3'd3,
        TK_DIST = 3'd4,
        TK_LOW  = 3'd5
    } tok_t;

    typedef enum logic [1:0] {
        HP_MODE = 2'd0,
        HP_WIN  = 2'd1,
        HP_DATA = 2'd2
    } hdr_t;

    typedef enum logic [1:0] {
        FS_IDLE  = 2'd0,
        FS_PARSE = 2'd1,
        FS_EMIT  = 2'd2
    } fstate_t;

    typedef enum logic [1:0] {
        BS_IDLE = 2'd0,
        BS_RD   = 2'd1,
        BS_WR   = 2'd2
    } bstate_t;

    function automatic logic [3:0] len_bits(input logic [3:0] i);
        logic [3:0] r;
        case (i)
            4'd0: r = 4'd3;  4'd1: r = 4'd2;  4'd2: r = 4'd3;  4'd3: r = 4'd3;
            4'd4: r = 4'd4;  4'd5: r = 4'd4;  4'd6: r = 4'd4;  4'd7: r = 4'd5;
            4'd8: r = 4'd5;  4'd9: r = 4'd5;  4'd10: r = 4'd5; 4'd11: r = 4'd6;
            4'd12: r = 4'd6; 4'd13: r = 4'd6; 4'd14: r = 4'd7; default: r = 4'd7;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] len_code(input logic [3:0] i);
        logic [7:0] r;
        case (i)
            4'd0: r = 8'd5;   4'd1: r = 8'd3;   4'd2: r = 8'd1;   4'd3: r = 8'd6;
            4'd4: r = 8'd10;  4'd5: r = 8'd2;   4'd6: r = 8'd12;  4'd7: r = 8'd20;
            4'd8: r = 8'd4;   4'd9: r = 8'd24;  4'd10: r = 8'd8;  4'd11: r = 8'd48;
            4'd12: r = 8'd16; 4'd13: r = 8'd32; 4'd14: r = 8'd64; default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [9:0] len_base(input logic [3:0] i);
        logic [9:0] r;
        case (i)
            4'd0: r = 10'd2;    4'd1: r = 10'd3;    4'd2: r = 10'd4;   4'd3: r = 10'd5;
            4'd4: r = 10'd6;    4'd5: r = 10'd7;    4'd6: r = 10'd8;   4'd7: r = 10'd9;
            4'd8: r = 10'd10;   4'd9: r = 10'd12;   4'd10: r = 10'd16; 4'd11: r = 10'd24;
            4'd12: r = 10'd40;  4'd13: r = 10'd72;  4'd14: r = 10'd136;
            default: r = 10'd264;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] len_extra(input logic [3:0] i);
        return (i < 4'd8) ? 4'd0 : (i - 4'd7);
    endfunction

    function automatic logic [3:0] dist_bits(input logic [5:0] i);
        logic [3:0] r;
        if (i == 6'd0)       r = 4'd2;
        else if (i < 6'd3)   r = 4'd4;
        else if (i < 6'd7)   r = 4'd5;
        else if (i < 6'd22)  r = 4'd6;
        else if (i < 6'd48)  r = 4'd7;
        else                 r = 4'd8;
        return r;
    endfunction

    function automatic logic [7:0] dist_code(input logic [5:0] i);
        logic [7:0] r;
        case (i)
            6'd0: r = 8'd3;    6'd1: r = 8'd13;   6'd2: r = 8'd5;    6'd3: r = 8'd25;
            6'd4: r = 8'd9;    6'd5: r = 8'd17;   6'd6: r = 8'd1;    6'd7: r = 8'd62;
            6'd8: r = 8'd30;   6'd9: r = 8'd46;   6'd10: r = 8'd14;  6'd11: r = 8'd54;
            6'd12: r = 8'd22;  6'd13: r = 8'd38;  6'd14: r = 8'd6;   6'd15: r = 8'd58;
            6'd16: r = 8'd26;  6'd17: r = 8'd42;  6'd18: r = 8'd10;  6'd19: r = 8'd50;
            6'd20: r = 8'd18;  6'd21: r = 8'd34;  6'd22: r = 8'd66;  6'd23: r = 8'd2;
            6'd24: r = 8'd124; 6'd25: r = 8'd60;  6'd26: r = 8'd92;  6'd27: r = 8'd28;
            6'd28: r = 8'd108; 6'd29: r = 8'd44;  6'd30: r = 8'd76;  6'd31: r = 8'd12;
            6'd32: r = 8'd116; 6'd33: r = 8'd52;  6'd34: r = 8'd84;  6'd35: r = 8'd20;
            6'd36: r = 8'd100; 6'd37: r = 8'd36;  6'd38: r = 8'd68;  6'd39: r = 8'd4;
            6'd40: r = 8'd120; 6'd41: r = 8'd56;  6'd42: r = 8'd88;  6'd43: r = 8'd24;
            6'd44: r = 8'd104; 6'd45: r = 8'd40;  6'd46: r = 8'd72;  6'd47: r = 8'd8;
            6'd48: r = 8'd240; 6'd49: r = 8'd112; 6'd50: r = 8'd176; 6'd51: r = 8'd48;
            6'd52: r = 8'd208; 6'd53: r = 8'd80;  6'd54: r = 8'd144; 6'd55: r = 8'd16;
            6'd56: r = 8'd224; 6'd57: r = 8'd96;  6'd58: r = 8'd160; 6'd59: r = 8'd32;
            6'd60: r = 8'd192; 6'd61: r = 8'd64;  6'd62: r = 8'd128; default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/dcl_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcl_front
// Header handling and bit parser: turns stream bytes into literal, copy and
// end-of-item commands for the back end.
// ----------------------------------------------------------------------------
module dcl_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                restart,
    output logic                cmd_valid,
    input  logic                cmd_stall,
    output dcl_pkg::cmd_t       cmd
);

    localparam int HISTORY_AW = dcl_pkg::HistAw;

    dcl_pkg::fstate_t   st_reg, st_next;
    dcl_pkg::hdr_t      hp_reg, hp_next;
    dcl_pkg::tok_t      tk_reg, tk_next;
    logic [15:0]        buf_reg, buf_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [2:0]         win_reg, win_next;
    logic [12:0]        prod_reg, prod_next;
    logic               stop_reg, stop_next;
    logic [9:0]         len_reg, len_next;
    logic [3:0]         lidx_reg, lidx_next;
    logic [5:0]         dhi_reg, dhi_next;
    logic               any_reg, any_next;
    logic               end_reg, end_next;
    dcl_pkg::err_t      err_reg, err_next;

    // combinational prefix matches (first match in table order)
    logic               lm_hit;
    logic [3:0]         lm_idx;
    logic               dm_hit;
    logic [5:0]         dm_idx;
    logic [3:0]         ext;
    logic [3:0]         lowb;
    logic [15:0]        msk;
    logic [HISTORY_AW:0] back;

    always_comb
    begin
        lm_hit = 1'b0;
        lm_idx = 4'd0;
        for (int i = 15; i >= 0; i--)
        begin
            if ({1'b0, dcl_pkg::len_bits(4'(i))} <= cnt_reg &&
                (buf_reg[7:0] & 8'((9'd1 << dcl_pkg::len_bits(4'(i))) - 9'd1))
                    == dcl_pkg::len_code(4'(i)))
            begin
                lm_hit = 1'b1;
                lm_idx = 4'(i);
            end
        end
    end

    always_comb
    begin
        dm_hit = 1'b0;
        dm_idx = 6'd0;
        for (int i = 63; i >= 0; i--)
        begin
            if ({1'b0, dcl_pkg::dist_bits(6'(i))} <= cnt_reg &&
                (buf_reg[7:0] & 8'((9'd1 << dcl_pkg::dist_bits(6'(i))) - 9'd1))
                    == dcl_pkg::dist_code(6'(i)))
            begin
                dm_hit = 1'b1;
                dm_idx = 6'(i);
            end
        end
    end

    assign ext  = dcl_pkg::len_extra(lidx_reg);
    assign lowb = (len_reg == 10'd2) ? 4'd2 : {1'b0, win_reg};
    assign back = (HISTORY_AW + 1)'((({7'd0, dhi_reg} << lowb) |
                  (13'(buf_reg[7:0]) & 13'((9'd1 << lowb) - 9'd1))) + 13'd1);
    assign msk  = 16'((17'd1 << ext) - 17'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= dcl_pkg::FS_IDLE;
            hp_reg   <= dcl_pkg::HP_MODE;
            tk_reg   <= dcl_pkg::TK_FLAG;
            buf_reg  <= '0;
            cnt_reg  <= '0;
            win_reg  <= '0;
            prod_reg <= '0;
            stop_reg <= 1'b0;
            len_reg  <= '0;
            lidx_reg <= '0;
            dhi_reg  <= '0;
            any_reg  <= 1'b0;
            end_reg  <= 1'b0;
            err_reg  <= dcl_pkg::ERR_NONE;
        end
        else
        begin
            st_reg   <= st_next;
            hp_reg   <= hp_next;
            tk_reg   <= tk_next;
            buf_reg  <= buf_next;
            cnt_reg  <= cnt_next;
            win_reg  <= win_next;
            prod_reg <= prod_next;
            stop_reg <= stop_next;
            len_reg  <= len_next;
            lidx_reg <= lidx_next;
            dhi_reg  <= dhi_next;
            any_reg  <= any_next;
            end_reg  <= end_next;
            err_reg  <= err_next;
        end
    end

    // one token step per cycle while no command is held by cmd_stall; emit one command per step that makes bytes
    always_comb
    begin
        st_next   = st_reg;
        hp_next   = hp_reg;
        tk_next   = tk_reg;
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        win_next  = win_reg;
        prod_next = prod_reg;
        stop_next = stop_reg;
        len_next  = len_reg;
        lidx_next = lidx_reg;
        dhi_next  = dhi_reg;
        any_next  = any_reg;
        end_next  = end_reg;
        err_next  = err_reg;
        in_stall  = 1'b1;
        cmd_valid = 1'b0;
        cmd       = '0;
        case (st_reg)
            dcl_pkg::FS_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    st_next   = dcl_pkg::FS_EMIT;
                    any_next  = 1'b0;
                    end_next  = 1'b0;
                    err_next  = dcl_pkg::ERR_NONE;
                    // header handling and restart are settled on acceptance
                    if (restart)
                    begin
                        buf_next = '0; cnt_next = '0; win_next = '0; prod_next = '0;
                        stop_next = 1'b0; tk_next = dcl_pkg::TK_FLAG;
                        len_next = '0; lidx_next = '0; dhi_next = '0;
                        hp_next = dcl_pkg::HP_WIN;
                        st_next = dcl_pkg::FS_IDLE;
                    end
                    else if (stop_reg)
                        st_next = dcl_pkg::FS_IDLE;
                    else if (hp_reg == dcl_pkg::HP_MODE)
                    begin
                        hp_next = dcl_pkg::HP_WIN;
                        st_next = dcl_pkg::FS_IDLE;
                    end
                    else if (hp_reg == dcl_pkg::HP_WIN)
                    begin
                        if (data_byte >= 8'd4 && data_byte <= 8'd6)
                        begin
                            win_next = data_byte[2:0];
                            hp_next  = dcl_pkg::HP_DATA;
                            st_next  = dcl_pkg::FS_IDLE;
                        end
                        else
                        begin
                            err_next  = dcl_pkg::ERR_WIN;
                            stop_next = 1'b1;
                        end
                    end
                    else
                    begin
                        buf_next = buf_reg | (16'(data_byte) << cnt_reg[2:0]);
                        cnt_next = cnt_reg + 5'd8;
                        st_next  = dcl_pkg::FS_PARSE;
                    end
                end
            end
            dcl_pkg::FS_PARSE:
            begin
                case (tk_reg)
                    dcl_pkg::TK_FLAG:
                    begin
                        if (cnt_reg != 5'd0)
                        begin
                            tk_next  = buf_reg[0] ? dcl_pkg::TK_LEN : dcl_pkg::TK_LIT;
                            buf_next = buf_reg >> 1;
                            cnt_next = cnt_reg - 5'd1;
                        end
                        else
                            st_next = any_reg ? dcl_pkg::FS_EMIT : dcl_pkg::FS_IDLE;
                    end
                    dcl_pkg::TK_LIT:
                    begin
                        if (cnt_reg >= 5'd8)
                        begin
                            cmd_valid = 1'b1;
                            cmd.op    = dcl_pkg::OP_LIT;
                            cmd.lit   = buf_reg[7:0];
                            if (!cmd_stall)
                            begin
                                buf_next  = buf_reg >> 8;
                                cnt_next  = cnt_reg - 5'd8;
                                tk_next   = dcl_pkg::TK_FLAG;
                                any_next  = 1'b1;
                                prod_next = (prod_reg == 13'd4096) ? prod_reg : prod_reg + 13'd1;
                            end
                        end
                        else
                            st_next = any_reg ? dcl_pkg::FS_EMIT : dcl_pkg::FS_IDLE;
                    end
                    dcl_pkg::TK_LEN:
                    begin
                        if (lm_hit)
                        begin
                            buf_next  = buf_reg >> dcl_pkg::len_bits(lm_idx);
                            cnt_next  = cnt_reg - 5'(dcl_pkg::len_bits(lm_idx));
                            lidx_next = lm_idx;
                            len_next  = dcl_pkg::len_base(lm_idx);
                            tk_next   = (dcl_pkg::len_extra(lm_idx) != 4'd0) ?
                                        dcl_pkg::TK_EXT : dcl_pkg::TK_DIST;
                        end
                        else
                            st_next = any_reg ? dcl_pkg::FS_EMIT : dcl_pkg::FS_IDLE;
                    end
                    dcl_pkg::TK_EXT:
                    begin
                        if (cnt_reg >= 5'(ext))
                        begin
                            if (ext == 4'd8 && buf_reg[7:0] == 8'hff)
                            begin
                                end_next  = 1'b1;
                                stop_next = 1'b1;
                                st_next   = dcl_pkg::FS_EMIT;
                            end
                            else
                            begin
                                buf_next = buf_reg >> ext;
                                cnt_next = cnt_reg - 5'(ext);
                                len_next = len_reg + 10'(buf_reg & msk);
                                tk_next  = dcl_pkg::TK_DIST;
                            end
                        end
                        else
                            st_next = any_reg ? dcl_pkg::FS_EMIT : dcl_pkg::FS_IDLE;
                    end
                    dcl_pkg::TK_DIST:
                    begin
                        if (dm_hit)
                        begin
                            buf_next = buf_reg >> dcl_pkg::dist_bits(dm_idx);
                            cnt_next = cnt_reg - 5'(dcl_pkg::dist_bits(dm_idx));
                            dhi_next = dm_idx;
                            tk_next  = dcl_pkg::TK_LOW;
                        end
                        else
                            st_next = any_reg ? dcl_pkg::FS_EMIT : dcl_pkg::FS_IDLE;
                    end
                    default:
                    begin
                        if (cnt_reg >= 5'(lowb))
                        begin
                            if (13'(back) > prod_reg)
                            begin
                                buf_next  = buf_reg >> lowb;
                                cnt_next  = cnt_reg - 5'(lowb);
                                tk_next   = dcl_pkg::TK_FLAG;
                                err_next  = dcl_pkg::ERR_DIST;
                                stop_next = 1'b1;
                                st_next   = dcl_pkg::FS_EMIT;
                            end
                            else
                            begin
                                cmd_valid = 1'b1;
                                cmd.op    = dcl_pkg::OP_COPY;
                                cmd.len   = len_reg;
                                cmd.back  = back;
                                if (!cmd_stall)
                                begin
                                    buf_next  = buf_reg >> lowb;
                                    cnt_next  = cnt_reg - 5'(lowb);
                                    tk_next   = dcl_pkg::TK_FLAG;
                                    any_next  = 1'b1;
                                    prod_next = (prod_reg + 13'(len_reg) > 13'd4096) ?
                                                13'd4096 : prod_reg + 13'(len_reg);
                                end
                            end
                        end
                        else
                            st_next = any_reg ? dcl_pkg::FS_EMIT : dcl_pkg::FS_IDLE;
                    end
                endcase
            end
            dcl_pkg::FS_EMIT:
            begin
                // close the item: flush and tag the final result
                cmd_valid   = 1'b1;
                cmd.op      = dcl_pkg::OP_DONE;
                cmd.last    = 1'b1;
                cmd.fin_end = end_reg;
                cmd.err     = err_reg;
                if (!cmd_stall)
                    st_next = dcl_pkg::FS_IDLE;
            end
            default:
                st_next = dcl_pkg::FS_IDLE;
        endcase
    end

endmodule

// ----- src/dcl_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcl_queue
// Two-entry command queue between parser and byte writer.
// ----------------------------------------------------------------------------
module dcl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  dcl_pkg::cmd_t   in_cmd,
    output logic            out_valid,
    input  logic            out_stall,
    output dcl_pkg::cmd_t   out_cmd
);

    dcl_pkg::cmd_t  mem_reg [dcl_pkg::QDepth];
    logic           wp_reg, wp_next;
    logic           rp_reg, rp_next;
    logic [1:0]     n_reg, n_next;
    logic           push, pop;

    assign in_stall  = (n_reg == 2'(dcl_pkg::QDepth));
    assign out_valid = (n_reg != 2'd0);
    assign out_cmd   = mem_reg[rp_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;

    // advance pointers and count
    always_comb
    begin
        wp_next = push ? ~wp_reg : wp_reg;
        rp_next = pop ? ~rp_reg : rp_reg;
        n_next  = n_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            n_reg  <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            n_reg  <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_cmd;
    end

endmodule

// ----- src/dcl_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcl_back
// Byte writer: history memory, copy engine and 16-byte result packer.
// ----------------------------------------------------------------------------
module dcl_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            restart_pulse,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  dcl_pkg::cmd_t   cmd,
    output logic            valid,
    input  logic            stall,
    output logic [63:0]     bytes_low,
    output logic [63:0]     bytes_high,
    output logic [4:0]      byte_count,
    output logic            last_of_run,
    output logic            stream_end,
    output logic [1:0]      error_code
);

    localparam int AW = dcl_pkg::HistAw;
    localparam int NB = dcl_pkg::BytesPerRes;
    localparam int CW = dcl_pkg::CntW;

    logic [7:0]         hist [dcl_pkg::HistDepth];
    logic [7:0]         rd_reg;
    dcl_pkg::bstate_t   st_reg, st_next;
    logic [AW-1:0]      wp_reg, wp_next;
    logic [9:0]         left_reg, left_next;
    logic [AW-1:0]      src_reg, src_next;
    logic [8*NB-1:0]    pk_reg, pk_next;
    logic [CW-1:0]      pc_reg, pc_next;
    logic               ov_reg, ov_next;
    logic [8*NB-1:0]    ob_reg, ob_next;
    logic [CW-1:0]      oc_reg, oc_next;
    logic               ol_reg, ol_next;
    logic               oe_reg, oe_next;
    logic [1:0]         oerr_reg, oerr_next;
    logic               we;
    logic [7:0]         wd;
    logic               ob_free;
    logic               pk_full;
    logic               done_now;
    logic               ship_full;

    assign ob_free = !ov_reg || !stall;
    assign pk_full = (pc_reg == CW'(NB));
    // a full pack closes the item itself when the next command is the close
    assign done_now  = (st_reg == dcl_pkg::BS_IDLE) && cmd_valid &&
                       (cmd.op == dcl_pkg::OP_DONE);
    assign ship_full = pk_full && !((st_reg == dcl_pkg::BS_IDLE) &&
                       (!cmd_valid || cmd.op == dcl_pkg::OP_DONE));

    assign valid       = ov_reg;
    assign bytes_low   = ob_reg[63:0];
    assign bytes_high  = 64'(ob_reg[8*NB-1:64]);
    assign byte_count  = 5'(oc_reg);
    assign last_of_run = ol_reg;
    assign stream_end  = oe_reg;
    assign error_code  = oerr_reg;

    // history memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
            hist[wp_reg] <= wd;
        rd_reg <= hist[src_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= dcl_pkg::BS_IDLE;
            wp_reg <= '0;
            pc_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            wp_reg <= wp_next;
            pc_reg <= pc_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        src_reg  <= src_next;
        pk_reg   <= pk_next;
        ob_reg   <= ob_next;
        oc_reg   <= oc_next;
        ol_reg   <= ol_next;
        oe_reg   <= oe_next;
        oerr_reg <= oerr_next;
    end

    // execute commands: a literal is written directly; a copy alternates BS_RD and BS_WR for each byte
    always_comb
    begin
        st_next   = st_reg;
        wp_next   = restart_pulse ? '0 : wp_reg;
        left_next = left_reg;
        src_next  = src_reg;
        pk_next   = pk_reg;
        pc_next   = pc_reg;
        ov_next   = ov_reg && stall;
        ob_next   = ob_reg;
        oc_next   = oc_reg;
        ol_next   = ol_reg;
        oe_next   = oe_reg;
        oerr_next = oerr_reg;
        cmd_stall = 1'b1;
        we        = 1'b0;
        wd        = rd_reg;
        // ship a full pack once another byte of the item is on its way
        if (ship_full)
        begin
            if (ob_free)
            begin
                ov_next   = 1'b1;
                ob_next   = pk_reg;
                oc_next   = pc_reg;
                ol_next   = 1'b0;
                oe_next   = 1'b0;
                oerr_next = dcl_pkg::ERR_NONE;
                pc_next   = '0;
            end
        end
        else if (!pk_full || done_now)
        begin
            case (st_reg)
                dcl_pkg::BS_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        case (cmd.op)
                            dcl_pkg::OP_LIT:
                            begin
                                cmd_stall = 1'b0;
                                we = 1'b1;
                                wd = cmd.lit;
                                wp_next = wp_reg + AW'(1);
                                pk_next[8*pc_reg[CW-2:0] +: 8] = cmd.lit;
                                pc_next = pc_reg + CW'(1);
                            end
                            dcl_pkg::OP_COPY:
                            begin
                                cmd_stall = 1'b0;
                                left_next = cmd.len;
                                src_next  = wp_reg - AW'(cmd.back);
                                st_next   = dcl_pkg::BS_RD;
                            end
                            default:
                            begin
                                if (ob_free)
                                begin
                                    cmd_stall = 1'b0;
                                    ov_next   = 1'b1;
                                    ob_next   = pk_reg;
                                    for (int j = 0; j < NB; j++)
                                        if (CW'(j) >= pc_reg)
                                            ob_next[8*j +: 8] = 8'd0;
                                    oc_next   = pc_reg;
                                    ol_next   = 1'b1;
                                    oe_next   = cmd.fin_end;
                                    oerr_next = cmd.err;
                                    pc_next   = '0;
                                    pk_next   = '0;
                                end
                            end
                        endcase
                    end
                end
                dcl_pkg::BS_RD:
                    st_next = dcl_pkg::BS_WR;
                default:
                begin
                    we = 1'b1;
                    wp_next = wp_reg + AW'(1);
                    src_next = src_reg + AW'(1);
                    pk_next[8*pc_reg[CW-2:0] +: 8] = rd_reg;
                    pc_next = pc_reg + CW'(1);
                    left_next = left_reg - 10'd1;
                    st_next = (left_reg == 10'd1) ? dcl_pkg::BS_IDLE : dcl_pkg::BS_RD;
                end
            endcase
        end
    end

endmodule

// ----- src/dcl_implode_decompressor_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcl_implode_decompressor_core
// Binary-mode implode stream decoder: parser front end, command queue and
// history/copy back end.
// ----------------------------------------------------------------------------
// channel | signals                                   | direction
// input   | valid, stall, data_byte, restart          | in (stall out)
// result  | out_valid, out_stall, bytes_*, byte_count,| out (stall in)
//         | last_of_run, stream_end, error_code       |
// Header bytes are taken in the idle state. A data byte is accepted, then parsed
// token step by token step until the next code is incomplete, and an item that
// made bytes, ended or failed is then closed. Each copied byte is read from
// history and then written; a full result is shipped between bytes.
// Reset clears all control state; history is undefined until written. Input
// stalls while parsing or closing an item; the back end can stall the queue.
// ----------------------------------------------------------------------------
module dcl_implode_decompressor_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        stall,
    input  logic [7:0]  data_byte,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] bytes_low,
    output logic [63:0] bytes_high,
    output logic [4:0]  byte_count,
    output logic        last_of_run,
    output logic        stream_end,
    output logic [1:0]  error_code
);

    logic           f_valid, f_stall, b_valid, b_stall;
    dcl_pkg::cmd_t  f_cmd, b_cmd;

    dcl_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(valid), .in_stall(stall),
        .data_byte(data_byte), .restart(restart),
        .cmd_valid(f_valid), .cmd_stall(f_stall), .cmd(f_cmd)
    );

    dcl_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_stall(f_stall), .in_cmd(f_cmd),
        .out_valid(b_valid), .out_stall(b_stall), .out_cmd(b_cmd)
    );

    dcl_back u_back (
        .clk(clk), .rst_n(rst_n),
        .restart_pulse(1'b0),
        .cmd_valid(b_valid), .cmd_stall(b_stall), .cmd(b_cmd),
        .valid(out_valid), .stall(out_stall),
        .bytes_low(bytes_low), .bytes_high(bytes_high),
        .byte_count(byte_count), .last_of_run(last_of_run),
        .stream_end(stream_end), .error_code(error_code)
    );

endmodule

// ----- src/dcl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcl_checker
// Port-level checks on the result channel of the decoder.
// ----------------------------------------------------------------------------
module dcl_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [4:0]  byte_count,
    input  logic        last_of_run,
    input  logic        stream_end,
    input  logic [1:0]  error_code
);

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(byte_count))
        else $error("stalled result changed");

    // count never exceeds a full result
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_count <= 5'(dcl_pkg::BytesPerRes))
        else $error("byte count too large");

    // end and errors only on the final result
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> !stream_end && error_code == dcl_pkg::ERR_NONE)
        else $error("event on non-final result");

    // non-final results are full
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> byte_count == 5'(dcl_pkg::BytesPerRes))
        else $error("short non-final result");

endmodule

bind dcl_implode_decompressor_core dcl_checker u_dcl_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .byte_count(byte_count), .last_of_run(last_of_run),
    .stream_end(stream_end), .error_code(error_code)
);
